@@ sv/pdll_pkg.sv @@
// Shared types and codes for the pooled doubly linked list core.
package pdll_pkg;
	typedef enum logic [2:0] {
		ACT_CLEAR     = 3'd0,
		ACT_SEARCH    = 3'd1,
		ACT_INS_HEAD  = 3'd2,
		ACT_INS_TAIL  = 3'd3,
		ACT_INS_AFTER = 3'd4,
		ACT_INS_BEFORE = 3'd5,
		ACT_DELETE    = 3'd6,
		ACT_NONE      = 3'd7
	} action_t;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	typedef struct packed {
		action_t     action;
		logic [31:0] key_value;
		logic [31:0] new_value;
	} cmd_t;

	typedef struct packed {
		logic [1:0] status;
		logic [3:0] node_index;
		logic       index_valid;
	} rsp_t;
endpackage

@@ sv/pdll_if.sv @@
// Valid/ready channel interfaces for commands and responses.
interface pdll_cmd_if;
	logic             valid;
	logic             ready;
	logic [2:0]       action;
	logic signed [31:0] key_value;
	logic signed [31:0] new_value;
	modport source (output valid, action, key_value, new_value, input ready);
	modport sink (input valid, action, key_value, new_value, output ready);
endinterface

interface pdll_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [3:0] node_index;
	logic       index_valid;
	modport source (output valid, status, node_index, index_valid, input ready);
	modport sink (input valid, status, node_index, index_valid, output ready);
endinterface

@@ sv/pdll_front.sv @@
// Front end: accepts command beats into a short queue.
module pdll_front #(
	parameter int DEPTH = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	pdll_cmd_if.sink          cmd,
	output logic              q_valid,
	input  logic              q_pop,
	output pdll_pkg::cmd_t    q_cmd
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	pdll_pkg::cmd_t fifo_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   cnt_q;
	logic push;
	pdll_pkg::cmd_t in_cmd;

	always_comb begin
		in_cmd.action = pdll_pkg::action_t'(cmd.action);
		in_cmd.key_value = cmd.key_value;
		in_cmd.new_value = cmd.new_value;
	end

	assign cmd.ready = (cnt_q != (AW+1)'(DEPTH));
	assign push = cmd.valid && cmd.ready;
	assign q_valid = (cnt_q != '0);
	assign q_cmd = fifo_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_q] <= in_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
			if (q_pop) rd_q <= (rd_q == AW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(q_pop);
		end
	end
endmodule

@@ sv/pdll_back.sv @@
// Back end: walks the list link by link and applies list updates; it pops a new command only when idle.
module pdll_back #(
	parameter int POOL_SIZE = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	output logic              q_pop,
	input  pdll_pkg::cmd_t    q_cmd,
	pdll_rsp_if.source        rsp
);
	localparam int IW = $clog2(POOL_SIZE);
	localparam int LW = IW + 1;
	localparam int SW = $clog2(POOL_SIZE + 1);
	localparam logic [LW-1:0] NULL_L = LW'(POOL_SIZE);

	typedef enum logic [2:0] {S_IDLE, S_FREE, S_WALK, S_READ, S_APPLY, S_OUT} state_t;

	logic [31:0]   val_mem [POOL_SIZE];
	logic [LW-1:0] prv_mem [POOL_SIZE];
	logic [LW-1:0] nxt_mem [POOL_SIZE];
	logic [POOL_SIZE-1:0] used_q;
	logic [LW-1:0] head_q;

	state_t state_q;
	pdll_pkg::cmd_t cmd_q;
	logic [LW-1:0] p_q, n_q, q_q;
	logic [SW-1:0] steps_q;
	logic [31:0]   rd_val_q;
	logic [LW-1:0] rd_nxt_q, rd_prv_q;
	logic [1:0]    st_q;
	logic [3:0]    idx_q;
	logic          iv_q;
	logic          free_ok_q;
	logic [IW-1:0] free_idx_q;

	logic [IW-1:0] p_i, n_i, q_i;
	logic [IW-1:0] pe_idx;
	logic          pe_ok;

	assign p_i = p_q[IW-1:0];
	assign n_i = n_q[IW-1:0];
	assign q_i = q_q[IW-1:0];

	always_comb begin
		pe_ok = 1'b0;
		pe_idx = '0;
		for (int i = POOL_SIZE - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				pe_ok = 1'b1;
				pe_idx = IW'(i);
			end
		end
	end

	assign q_pop = (state_q == S_IDLE) && q_valid;
	assign rsp.valid = (state_q == S_OUT);
	assign rsp.status = st_q;
	assign rsp.node_index = idx_q;
	assign rsp.index_valid = iv_q;

	// Registered reads of the node arrays at p.
	always_ff @(posedge clk) begin
		rd_val_q <= val_mem[p_i];
		rd_nxt_q <= nxt_mem[p_i];
		rd_prv_q <= prv_mem[p_i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q <= '0;
			head_q <= NULL_L;
			st_q <= '0;
			idx_q <= '0;
			iv_q <= 1'b0;
			p_q <= NULL_L;
			n_q <= NULL_L;
			q_q <= NULL_L;
			steps_q <= '0;
			free_ok_q <= 1'b0;
			free_idx_q <= '0;
			cmd_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						cmd_q <= q_cmd;
						state_q <= S_FREE;
					end
				end
				S_FREE: begin
					free_ok_q <= pe_ok;
					free_idx_q <= pe_idx;
					p_q <= head_q;
					steps_q <= '0;
					idx_q <= '0;
					iv_q <= 1'b0;
					case (cmd_q.action)
						pdll_pkg::ACT_CLEAR: begin
							used_q <= '0;
							head_q <= NULL_L;
							st_q <= pdll_pkg::ST_DONE;
							state_q <= S_OUT;
						end
						pdll_pkg::ACT_INS_HEAD, pdll_pkg::ACT_INS_TAIL: begin
							if (!pe_ok) begin
								st_q <= pdll_pkg::ST_FULL;
								state_q <= S_OUT;
							end else if (cmd_q.action == pdll_pkg::ACT_INS_HEAD
									|| head_q >= NULL_L) begin
								st_q <= pdll_pkg::ST_DONE;
								state_q <= S_APPLY;
							end else begin
								st_q <= pdll_pkg::ST_DONE;
								state_q <= S_READ;
							end
						end
						pdll_pkg::ACT_SEARCH, pdll_pkg::ACT_INS_AFTER,
						pdll_pkg::ACT_INS_BEFORE, pdll_pkg::ACT_DELETE: begin
							if (head_q >= NULL_L) begin
								st_q <= pdll_pkg::ST_NOT_FOUND;
								state_q <= S_OUT;
							end else begin
								st_q <= pdll_pkg::ST_DONE;
								state_q <= S_READ;
							end
						end
						default: begin
							st_q <= pdll_pkg::ST_DONE;
							state_q <= S_OUT;
						end
					endcase
				end
				S_READ: state_q <= S_WALK;
				S_WALK: begin
					if (cmd_q.action == pdll_pkg::ACT_INS_TAIL) begin
						if (rd_nxt_q >= NULL_L || steps_q == SW'(POOL_SIZE - 1)) begin
							state_q <= S_APPLY;
						end else begin
							p_q <= rd_nxt_q;
							steps_q <= steps_q + 1'b1;
							state_q <= S_READ;
						end
					end else if (rd_val_q == cmd_q.key_value) begin
						n_q <= rd_nxt_q;
						q_q <= rd_prv_q;
						if (cmd_q.action == pdll_pkg::ACT_SEARCH) begin
							idx_q <= 4'(p_q);
							iv_q <= 1'b1;
							state_q <= S_OUT;
						end else if (cmd_q.action != pdll_pkg::ACT_DELETE && !free_ok_q) begin
							st_q <= pdll_pkg::ST_FULL;
							state_q <= S_OUT;
						end else begin
							state_q <= S_APPLY;
						end
					end else if (rd_nxt_q >= NULL_L || steps_q == SW'(POOL_SIZE - 1)) begin
						st_q <= pdll_pkg::ST_NOT_FOUND;
						state_q <= S_OUT;
					end else begin
						p_q <= rd_nxt_q;
						steps_q <= steps_q + 1'b1;
						state_q <= S_READ;
					end
				end
				S_APPLY: begin
					iv_q <= 1'b1;
					if (cmd_q.action == pdll_pkg::ACT_DELETE) begin
						idx_q <= 4'(p_q);
						used_q[p_i] <= 1'b0;
						if (q_q >= NULL_L) head_q <= n_q;
					end else begin
						idx_q <= 4'(free_idx_q);
						used_q[free_idx_q] <= 1'b1;
						if (cmd_q.action == pdll_pkg::ACT_INS_HEAD
								|| (cmd_q.action == pdll_pkg::ACT_INS_TAIL && head_q >= NULL_L))
							head_q <= LW'(free_idx_q);
						if (cmd_q.action == pdll_pkg::ACT_INS_BEFORE && q_q >= NULL_L)
							head_q <= LW'(free_idx_q);
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (rsp.ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Link and value writes, done in the apply cycle.
	always_ff @(posedge clk) begin
		if (state_q == S_APPLY) begin
			case (cmd_q.action)
				pdll_pkg::ACT_INS_HEAD: begin
					val_mem[free_idx_q] <= cmd_q.new_value;
					prv_mem[free_idx_q] <= NULL_L;
					nxt_mem[free_idx_q] <= head_q;
					if (head_q < NULL_L) prv_mem[head_q[IW-1:0]] <= LW'(free_idx_q);
				end
				pdll_pkg::ACT_INS_TAIL: begin
					val_mem[free_idx_q] <= cmd_q.new_value;
					nxt_mem[free_idx_q] <= NULL_L;
					if (head_q >= NULL_L) begin
						prv_mem[free_idx_q] <= NULL_L;
					end else begin
						nxt_mem[p_i] <= LW'(free_idx_q);
						prv_mem[free_idx_q] <= p_q;
					end
				end
				pdll_pkg::ACT_INS_AFTER: begin
					val_mem[free_idx_q] <= cmd_q.new_value;
					prv_mem[free_idx_q] <= p_q;
					nxt_mem[free_idx_q] <= n_q;
					nxt_mem[p_i] <= LW'(free_idx_q);
					if (n_q < NULL_L) prv_mem[n_i] <= LW'(free_idx_q);
				end
				pdll_pkg::ACT_INS_BEFORE: begin
					val_mem[free_idx_q] <= cmd_q.new_value;
					prv_mem[free_idx_q] <= q_q;
					nxt_mem[free_idx_q] <= p_q;
					prv_mem[p_i] <= LW'(free_idx_q);
					if (q_q < NULL_L) nxt_mem[q_i] <= LW'(free_idx_q);
				end
				pdll_pkg::ACT_DELETE: begin
					if (q_q < NULL_L) nxt_mem[q_i] <= n_q;
					if (n_q < NULL_L) prv_mem[n_i] <= q_q;
				end
				default: ;
			endcase
		end
	end
endmodule

@@ sv/pooled_doubly_linked_list_core.sv @@
// Top level of the pooled doubly linked list core.
// Command path: the beat enters the queue, then IDLE, FREE and OUT for clear, unused code,
// full pool and empty list, with APPLY before OUT for head insert; a walk adds READ and
// WALK per node visited, up to POOL_SIZE nodes, before OUT (search) or APPLY (insert, delete).
// Throughput: one command at a time in the back end; the queue takes up to two beats meanwhile.
// Reset: arst_n clears the used map, head pointer, queue and control state.
module pooled_doubly_linked_list_core #(
	parameter int POOL_SIZE = 16
) (
	input logic        clk,
	input logic        arst_n,
	pdll_cmd_if.sink   cmd,
	pdll_rsp_if.source rsp
);
	logic q_valid, q_pop;
	pdll_pkg::cmd_t q_cmd;

	pdll_front #(.DEPTH(2)) u_front (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd)
	);

	pdll_back #(.POOL_SIZE(POOL_SIZE)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd), .rsp(rsp)
	);
endmodule

@@ sv/pdll_checker.sv @@
// Port-level checks for the pooled doubly linked list core.
module pdll_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [1:0] rsp_status,
	input logic [3:0] rsp_node_index,
	input logic       rsp_index_valid
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
		else $error("response dropped while stalled");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_status <= pdll_pkg::ST_FULL)
		else $error("bad status code");
	a_idx: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_index_valid |-> rsp_node_index == 4'd0)
		else $error("index without valid");
	a_fail: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != pdll_pkg::ST_DONE |-> !rsp_index_valid)
		else $error("failed command reports index");
endmodule

bind pooled_doubly_linked_list_core pdll_checker u_chk (
	.clk(clk), .arst_n(arst_n), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
	.rsp_status(rsp.status), .rsp_node_index(rsp.node_index),
	.rsp_index_valid(rsp.index_valid)
);

@@ tb/tb_pooled_doubly_linked_list_core.sv @@
// Testbench for the pooled doubly linked list core: directed and random command traffic checked against a predictor.
module tb_pooled_doubly_linked_list_core;
	localparam int POOL = 16;
	localparam int NULL_PTR = POOL;
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	pdll_cmd_if cmd_ch();
	pdll_rsp_if rsp_ch();

	pooled_doubly_linked_list_core #(.POOL_SIZE(POOL)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch.sink),
		.rsp(rsp_ch.source)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic [31:0] vals [POOL];
	int          prv [POOL];
	int          nxt [POOL];
	bit          used [POOL];
	int          head;

	pdll_pkg::cmd_t cmd_queue[$];
	pdll_pkg::rsp_t rsp_expected[$];
	int   errors = 0;
	int   cycles = 0;
	int   beats_out = 0;
	int   beats_in = 0;
	int   cnt_found = 0;
	int   cnt_missing = 0;
	int   cnt_full = 0;
	bit   stim_done = 0;
	bit   quiet = 0;

	function automatic int list_len();
		int p, n;
		p = head;
		n = 0;
		while (p < POOL && n < POOL) begin
			p = nxt[p];
			n++;
		end
		return n;
	endfunction

	function automatic logic [31:0] pick_member();
		int p, k;
		p = head;
		k = $urandom_range(list_len() - 1, 0);
		repeat (k) p = nxt[p];
		return vals[p];
	endfunction

	function automatic int find_node(logic [31:0] key);
		int p;
		p = head;
		for (int s = 0; s < POOL && p < POOL; s++) begin
			if (vals[p] == key)
				return p;
			p = nxt[p];
		end
		return NULL_PTR;
	endfunction

	function automatic int grab_slot();
		for (int i = 0; i < POOL; i++)
			if (!used[i]) begin
				used[i] = 1;
				return i;
			end
		return NULL_PTR;
	endfunction

	function automatic pdll_pkg::rsp_t mk(pdll_pkg::status_t st, int idx, bit ok);
		pdll_pkg::rsp_t r;
		r.status = st;
		r.node_index = ok ? idx[3:0] : 4'd0;
		r.index_valid = ok;
		return r;
	endfunction

	function automatic pdll_pkg::rsp_t apply_list_cmd(pdll_pkg::cmd_t c);
		int p, n, q;
		case (c.action)
			pdll_pkg::ACT_CLEAR: begin
				foreach (used[i]) used[i] = 0;
				head = NULL_PTR;
				return mk(pdll_pkg::ST_DONE, 0, 0);
			end
			pdll_pkg::ACT_SEARCH: begin
				p = find_node(c.key_value);
				if (p >= POOL) return mk(pdll_pkg::ST_NOT_FOUND, 0, 0);
				return mk(pdll_pkg::ST_DONE, p, 1);
			end
			pdll_pkg::ACT_INS_HEAD: begin
				n = grab_slot();
				if (n >= POOL) return mk(pdll_pkg::ST_FULL, 0, 0);
				vals[n] = c.new_value;
				prv[n] = NULL_PTR;
				nxt[n] = head;
				if (head < POOL) prv[head] = n;
				head = n;
				return mk(pdll_pkg::ST_DONE, n, 1);
			end
			pdll_pkg::ACT_INS_TAIL: begin
				n = grab_slot();
				if (n >= POOL) return mk(pdll_pkg::ST_FULL, 0, 0);
				vals[n] = c.new_value;
				nxt[n] = NULL_PTR;
				if (head >= POOL) begin
					prv[n] = NULL_PTR;
					head = n;
				end else begin
					p = head;
					for (int s = 0; s < POOL && nxt[p] < POOL; s++) p = nxt[p];
					nxt[p] = n;
					prv[n] = p;
				end
				return mk(pdll_pkg::ST_DONE, n, 1);
			end
			pdll_pkg::ACT_INS_AFTER: begin
				p = find_node(c.key_value);
				if (p >= POOL) return mk(pdll_pkg::ST_NOT_FOUND, 0, 0);
				n = grab_slot();
				if (n >= POOL) return mk(pdll_pkg::ST_FULL, 0, 0);
				vals[n] = c.new_value;
				prv[n] = p;
				q = nxt[p];
				nxt[n] = q;
				nxt[p] = n;
				if (q < POOL) prv[q] = n;
				return mk(pdll_pkg::ST_DONE, n, 1);
			end
			pdll_pkg::ACT_INS_BEFORE: begin
				p = find_node(c.key_value);
				if (p >= POOL) return mk(pdll_pkg::ST_NOT_FOUND, 0, 0);
				n = grab_slot();
				if (n >= POOL) return mk(pdll_pkg::ST_FULL, 0, 0);
				vals[n] = c.new_value;
				q = prv[p];
				prv[n] = q;
				nxt[n] = p;
				prv[p] = n;
				if (q >= POOL) head = n;
				else nxt[q] = n;
				return mk(pdll_pkg::ST_DONE, n, 1);
			end
			pdll_pkg::ACT_DELETE: begin
				p = find_node(c.key_value);
				if (p >= POOL) return mk(pdll_pkg::ST_NOT_FOUND, 0, 0);
				q = prv[p];
				n = nxt[p];
				if (q >= POOL) head = n;
				else nxt[q] = n;
				if (n < POOL) prv[n] = q;
				used[p] = 0;
				return mk(pdll_pkg::ST_DONE, p, 1);
			end
			default: return mk(pdll_pkg::ST_DONE, 0, 0);
		endcase
	endfunction

	// Commands are generated against the predictor so keys can target live nodes.
	task automatic push_cmd(pdll_pkg::action_t a, logic [31:0] k, logic [31:0] v);
		pdll_pkg::cmd_t c;
		pdll_pkg::rsp_t r;
		c.action = a;
		c.key_value = k;
		c.new_value = v;
		r = apply_list_cmd(c);
		cmd_queue.push_back(c);
		rsp_expected.push_back(r);
		case (r.status)
			pdll_pkg::ST_DONE: cnt_found++;
			pdll_pkg::ST_NOT_FOUND: cnt_missing++;
			default: cnt_full++;
		endcase
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(3, 0))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return $urandom_range(7, 0);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] rand_key();
		if (list_len() > 0 && $urandom_range(9, 0) < 8)
			return pick_member();
		return rand_word();
	endfunction

	initial begin
		pdll_pkg::action_t a;
		head = NULL_PTR;
		foreach (used[i]) used[i] = 0;
		// directed: extremes, every action, empty list, full pool, unused code
		push_cmd(pdll_pkg::ACT_SEARCH, 32'd5, 32'd0);
		push_cmd(pdll_pkg::ACT_DELETE, 32'd5, 32'd0);
		push_cmd(pdll_pkg::ACT_INS_AFTER, 32'd5, 32'd1);
		push_cmd(pdll_pkg::ACT_INS_BEFORE, 32'd5, 32'd1);
		push_cmd(pdll_pkg::ACT_INS_TAIL, 32'd0, 32'h8000_0000);
		push_cmd(pdll_pkg::ACT_INS_HEAD, 32'hffff_ffff, 32'h7fff_ffff);
		push_cmd(pdll_pkg::ACT_INS_AFTER, 32'h8000_0000, 32'hffff_ffff);
		push_cmd(pdll_pkg::ACT_INS_BEFORE, 32'h7fff_ffff, 32'd0);
		push_cmd(pdll_pkg::ACT_SEARCH, 32'hffff_ffff, 32'h5555_5555);
		push_cmd(pdll_pkg::ACT_DELETE, 32'h7fff_ffff, 32'haaaa_aaaa);
		push_cmd(pdll_pkg::ACT_NONE, 32'hffff_ffff, 32'hffff_ffff);
		for (int i = 0; i < 14; i++)
			push_cmd(i[0] ? pdll_pkg::ACT_INS_TAIL : pdll_pkg::ACT_INS_HEAD, 32'd0,
				32'd100 + i);
		push_cmd(pdll_pkg::ACT_INS_HEAD, 32'd0, 32'd1);
		push_cmd(pdll_pkg::ACT_INS_AFTER, 32'd100, 32'd1);
		push_cmd(pdll_pkg::ACT_CLEAR, 32'd0, 32'd0);
		push_cmd(pdll_pkg::ACT_SEARCH, 32'd100, 32'd0);
		for (int i = 0; i < 1100; i++) begin
			if ($urandom_range(99, 0) < 2)
				a = pdll_pkg::ACT_CLEAR;
			else if ($urandom_range(99, 0) < 3)
				a = pdll_pkg::ACT_NONE;
			else if (list_len() < 4)
				a = pdll_pkg::action_t'($urandom_range(5, 2));
			else
				a = pdll_pkg::action_t'($urandom_range(6, 1));
			push_cmd(a, rand_key(), rand_word());
		end
		stim_done = 1;
	end

	// driver
	int  send_gap = 0;
	bit  have_beat = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
			cmd_ch.action <= '0;
			cmd_ch.key_value <= '0;
			cmd_ch.new_value <= '0;
			have_beat = 0;
		end else begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				beats_in++;
				have_beat = 0;
			end
			if (!have_beat && send_gap > 0) begin
				send_gap--;
				cmd_ch.valid <= 1'b0;
			end else if (!have_beat && beats_in < cmd_queue.size()) begin
				cmd_ch.valid <= 1'b1;
				cmd_ch.action <= cmd_queue[beats_in].action;
				cmd_ch.key_value <= cmd_queue[beats_in].key_value;
				cmd_ch.new_value <= cmd_queue[beats_in].new_value;
				have_beat = 1;
				if (!quiet && $urandom_range(9, 0) == 0)
					send_gap = $urandom_range(17, 1);
			end else if (!have_beat) begin
				cmd_ch.valid <= 1'b0;
			end
		end
	end

	// monitor and response stall
	int stall = 0;
	always @(posedge clk or negedge arst_n) begin
		pdll_pkg::rsp_t e;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (rsp_expected.size() <= beats_out) begin
					$error("response with nothing expected");
					errors++;
				end else begin
					e = rsp_expected[beats_out];
					if (rsp_ch.status !== e.status) begin
						$error("status exp %0d got %0d", e.status, rsp_ch.status);
						errors++;
					end
					if (rsp_ch.node_index !== e.node_index) begin
						$error("node_index exp %0d got %0d", e.node_index, rsp_ch.node_index);
						errors++;
					end
					if (rsp_ch.index_valid !== e.index_valid) begin
						$error("index_valid exp %0d got %0d", e.index_valid,
							rsp_ch.index_valid);
						errors++;
					end
				end
				beats_out++;
			end
			if (stall > 0) begin
				stall--;
				rsp_ch.ready <= 1'b0;
			end else if (!quiet && $urandom_range(9, 0) == 0) begin
				stall = $urandom_range(17, 1) - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		wait (stim_done);
		while (beats_out < rsp_expected.size() || beats_in < cmd_queue.size()) begin
			@(posedge clk);
			cycles++;
			if (beats_in > cmd_queue.size() - 150)
				quiet = 1;
			if (cycles > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycles);
				$display("tb_pooled_doubly_linked_list_core NOT OK");
				$finish;
			end
		end
		repeat (2 * POOL + 10) @(posedge clk);
		$display("%0d commands: %0d done, %0d key missing, %0d pool full",
			cmd_queue.size(), cnt_found, cnt_missing, cnt_full);
		$display("%0d responses checked, %0d mismatches", beats_out, errors);
		if (errors == 0 && beats_out == rsp_expected.size())
			$display("tb_pooled_doubly_linked_list_core OK");
		else
			$display("tb_pooled_doubly_linked_list_core NOT OK");
		$finish;
	end
endmodule

@@ filelist.f @@
sv/pdll_pkg.sv
sv/pdll_if.sv
sv/pdll_front.sv
sv/pdll_back.sv
sv/pooled_doubly_linked_list_core.sv
sv/pdll_checker.sv
tb/tb_pooled_doubly_linked_list_core.sv
